/* hdl/led_strip_spi_symbol_frame_encoder_unit_assert.svh */
// Assertion helpers for the RTL files; only lssfe_pos includes them.
`ifndef LED_STRIP_SPI_SYMBOL_FRAME_ENCODER_UNIT_ASSERT_SVH
`define LED_STRIP_SPI_SYMBOL_FRAME_ENCODER_UNIT_ASSERT_SVH

// Condition must hold at every clock edge out of reset.
`define LSSFE_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Antecedent implies the consequent in the next cycle.
`define LSSFE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

/* hdl/lssfe_pkg.sv */
`timescale 1ns / 1ps

package lssfe_pkg;

  localparam int LED_COUNT_DEF   = 104;
  localparam int RESET_BYTES_DEF = 31;
  localparam int BYTES_PER_LED   = 12;

  localparam logic [7:0] LED_MAX        = 8'hFF;
  localparam logic [3:0] ZERO_SYMBOL_RST = 4'b0001;
  localparam logic [3:0] ONE_SYMBOL_RST  = 4'b0111;
  localparam logic [3:0] WITHIN_LAST     = 4'(BYTES_PER_LED - 1);

  typedef enum logic [0:0] {
    CFG_ZERO_SYMBOL = 1'b0,
    CFG_ONE_SYMBOL  = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    logic       in_data;
    logic       led_end;
    logic       last;
    logic [3:0] slot;
  } pos_info_t;

  function automatic logic [7:0] take_amt(input logic [15:0] left);
    take_amt = (left < {8'd0, LED_MAX}) ? left[7:0] : LED_MAX;
  endfunction

  function automatic logic [3:0] sym_sel(input logic b, input logic [3:0] zero_sym,
                                         input logic [3:0] one_sym);
    sym_sel = b ? one_sym : zero_sym;
  endfunction

endpackage

/* hdl/lssfe_pos.sv */
`timescale 1ns / 1ps
`include "led_strip_spi_symbol_frame_encoder_unit_assert.svh"

module lssfe_pos import lssfe_pkg::*; #(
  parameter int LED_COUNT   = LED_COUNT_DEF,
  parameter int RESET_BYTES = RESET_BYTES_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      load,
  input  logic      step,
  output pos_info_t info
);

  localparam int DATA_BYTES  = LED_COUNT * BYTES_PER_LED;
  localparam int RAW_BYTES   = 2 * RESET_BYTES + DATA_BYTES;
  localparam int FRAME_BYTES = ((RAW_BYTES + 3) / 4) * 4;
  localparam int POS_W       = $clog2(FRAME_BYTES + 1);

  localparam logic [POS_W-1:0] DATA_START = POS_W'(RESET_BYTES);
  localparam logic [POS_W-1:0] DATA_END   = POS_W'(RESET_BYTES + DATA_BYTES);
  localparam logic [POS_W-1:0] LAST_POS   = POS_W'(FRAME_BYTES - 1);

  logic [POS_W-1:0] pos_r, pos_nxt;
  logic [3:0]       within_r, within_nxt;
  logic             in_data, last;

  assign in_data = (pos_r >= DATA_START) && (pos_r < DATA_END);
  assign last    = (pos_r == LAST_POS);

  always_comb begin
    info.in_data = in_data;
    info.led_end = in_data && (within_r == WITHIN_LAST);
    info.last    = last;
    info.slot    = within_r;
  end

  always_comb begin
    pos_nxt    = pos_r;
    within_nxt = within_r;
    if (load) begin
      pos_nxt    = '0;
      within_nxt = '0;
    end else if (step) begin
      if (last) begin
        pos_nxt    = '0;
        within_nxt = '0;
      end else begin
        pos_nxt = pos_r + POS_W'(1);
        if (in_data) begin
          within_nxt = (within_r == WITHIN_LAST) ? 4'd0 : within_r + 4'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r    <= '0;
      within_r <= '0;
    end else begin
      pos_r    <= pos_nxt;
      within_r <= within_nxt;
    end
  end

  `LSSFE_ASSERT_ALWAYS(a_pos_range, pos_r <= LAST_POS, "frame position out of range")
  `LSSFE_ASSERT_ALWAYS(a_within_range, within_r <= WITHIN_LAST, "led byte index out of range")
  `LSSFE_ASSERT_ALWAYS(a_led_aligned, (pos_r != DATA_END) || (within_r == 4'd0),
                       "data region ended inside an led")
  `LSSFE_ASSERT_NEXT(a_wrap, step && !load && last, pos_r == '0 && within_r == 4'd0,
                     "frame did not wrap after last beat")

endmodule

/* hdl/lssfe_enc.sv */
`timescale 1ns / 1ps

module lssfe_enc import lssfe_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      load,
  input  logic      step,
  input  pos_info_t info,
  input  logic [15:0] red_total,
  input  logic [15:0] green_total,
  input  logic [15:0] blue_total,
  input  logic [3:0]  zero_symbol,
  input  logic [3:0]  one_symbol,
  output logic [7:0]  frame_byte
);

  logic [15:0] held_red_r, held_green_r, held_blue_r;
  logic [15:0] left_red_r, left_green_r, left_blue_r;
  logic [15:0] held_red_nxt, held_green_nxt, held_blue_nxt;
  logic [15:0] left_red_nxt, left_green_nxt, left_blue_nxt;
  logic [7:0]  value;
  logic [2:0]  hi_bit, lo_bit;

  always_comb begin
    case (info.slot[3:2])
      2'd0:    value = take_amt(left_green_r);
      2'd1:    value = take_amt(left_red_r);
      default: value = take_amt(left_blue_r);
    endcase
    hi_bit = 3'd7 - {info.slot[1:0], 1'b0};
    lo_bit = hi_bit - 3'd1;
    frame_byte = '0;
    if (info.in_data) begin
      frame_byte = {sym_sel(value[lo_bit], zero_symbol, one_symbol),
                    sym_sel(value[hi_bit], zero_symbol, one_symbol)};
    end
  end

  always_comb begin
    held_red_nxt   = held_red_r;
    held_green_nxt = held_green_r;
    held_blue_nxt  = held_blue_r;
    left_red_nxt   = left_red_r;
    left_green_nxt = left_green_r;
    left_blue_nxt  = left_blue_r;
    if (load) begin
      held_red_nxt   = red_total;
      held_green_nxt = green_total;
      held_blue_nxt  = blue_total;
      left_red_nxt   = red_total;
      left_green_nxt = green_total;
      left_blue_nxt  = blue_total;
    end else if (step) begin
      if (info.last) begin
        left_red_nxt   = held_red_r;
        left_green_nxt = held_green_r;
        left_blue_nxt  = held_blue_r;
      end else if (info.led_end) begin
        left_red_nxt   = left_red_r - {8'd0, take_amt(left_red_r)};
        left_green_nxt = left_green_r - {8'd0, take_amt(left_green_r)};
        left_blue_nxt  = left_blue_r - {8'd0, take_amt(left_blue_r)};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_red_r   <= '0;
      held_green_r <= '0;
      held_blue_r  <= '0;
      left_red_r   <= '0;
      left_green_r <= '0;
      left_blue_r  <= '0;
    end else begin
      held_red_r   <= held_red_nxt;
      held_green_r <= held_green_nxt;
      held_blue_r  <= held_blue_nxt;
      left_red_r   <= left_red_nxt;
      left_green_r <= left_green_nxt;
      left_blue_r  <= left_blue_nxt;
    end
  end

endmodule

/* hdl/led_strip_spi_symbol_frame_encoder_unit.sv */
`timescale 1ns / 1ps
// LED-strip SPI symbol frame encoder.
// Input channel (in_valid / in_stall): in_mode 0 loads red/green/blue totals and
// restarts the frame, producing no output beat; in_mode 1 fetches the next frame byte.
// Output channel (out_valid / out_stall): one beat per fetch carrying out_frame_byte
// and out_frame_last, which marks the final padded byte before the frame repeats.
// Config channel (cfg_valid / cfg_ready, always ready): index 0 sets the zero-bit
// symbol, index 1 the one-bit symbol; write only while the block is idle.
// A fetch reaches the output through the input register, then the result register.
// Throughput: one item per cycle while out_stall is low, set by the position
// counter and encode path.
// When out_stall holds a waiting result, one more item is taken into the input
// register; in_stall rises only while that register is also blocked. Loads drain
// through the input register without needing the output side.
// Reset (rst_n low, synchronous) empties both registers, restores symbols 0001
// and 0111, zeroes the totals and points at the start of the frame.

module led_strip_spi_symbol_frame_encoder_unit import lssfe_pkg::*; #(
  parameter int LED_COUNT   = LED_COUNT_DEF,
  parameter int RESET_BYTES = RESET_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_mode,
  input  logic [15:0] in_red_total,
  input  logic [15:0] in_green_total,
  input  logic [15:0] in_blue_total,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_frame_byte,
  output logic        out_frame_last,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  cfg_reg_t    cfg_index,
  input  logic [3:0]  cfg_data
);

  logic        in_valid_r, in_valid_nxt;
  logic        mode_r;
  logic [15:0] red_r, green_r, blue_r;
  logic        out_valid_r, out_valid_nxt;
  logic [7:0]  byte_r;
  logic        last_r;
  logic [3:0]  zero_sym_r, one_sym_r;
  logic        out_free, advance, accept_in, load, step;
  pos_info_t   info;
  logic [7:0]  enc_byte;

  assign out_free  = !out_valid_r || !out_stall;
  assign advance   = in_valid_r && (!mode_r || out_free);
  assign in_stall  = in_valid_r && !advance;
  assign accept_in = in_valid && !in_stall;
  assign load      = advance && !mode_r;
  assign step      = advance && mode_r;
  assign cfg_ready = 1'b1;

  assign out_valid      = out_valid_r;
  assign out_frame_byte = byte_r;
  assign out_frame_last = last_r;

  always_comb begin
    in_valid_nxt = in_valid_r;
    if (accept_in) begin
      in_valid_nxt = 1'b1;
    end else if (advance) begin
      in_valid_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (step) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      zero_sym_r  <= ZERO_SYMBOL_RST;
      one_sym_r   <= ONE_SYMBOL_RST;
    end else begin
      in_valid_r  <= in_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_ZERO_SYMBOL: zero_sym_r <= cfg_data;
          CFG_ONE_SYMBOL:  one_sym_r  <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept_in) begin
      mode_r  <= in_mode;
      red_r   <= in_red_total;
      green_r <= in_green_total;
      blue_r  <= in_blue_total;
    end
    if (step) begin
      byte_r <= enc_byte;
      last_r <= info.last;
    end
  end

  lssfe_pos #(
    .LED_COUNT   (LED_COUNT),
    .RESET_BYTES (RESET_BYTES)
  ) u_pos (
    .clk   (clk),
    .rst_n (rst_n),
    .load  (load),
    .step  (step),
    .info  (info)
  );

  lssfe_enc u_enc (
    .clk         (clk),
    .rst_n       (rst_n),
    .load        (load),
    .step        (step),
    .info        (info),
    .red_total   (red_r),
    .green_total (green_r),
    .blue_total  (blue_r),
    .zero_symbol (zero_sym_r),
    .one_symbol  (one_sym_r),
    .frame_byte  (enc_byte)
  );

endmodule

/* verif/testbench.sv */
`timescale 1ns / 1ps

module testbench;
  import lssfe_pkg::*;

  localparam logic MODE_LOAD  = 1'b0;
  localparam logic MODE_FETCH = 1'b1;
  localparam int DATA_LEN  = LED_COUNT_DEF * BYTES_PER_LED;
  localparam int FRAME_LEN = (2 * RESET_BYTES_DEF + DATA_LEN + 3) / 4 * 4;
  localparam int LATENCY   = 2;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } frame_beat_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        in_mode = MODE_FETCH;
  logic [15:0] in_red_total = '0;
  logic [15:0] in_green_total = '0;
  logic [15:0] in_blue_total = '0;
  logic        out_valid;
  logic        out_stall;
  logic [7:0]  out_frame_byte;
  logic        out_frame_last;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  cfg_reg_t    cfg_index = CFG_ZERO_SYMBOL;
  logic [3:0]  cfg_data = '0;

  logic rand_stall = 1'b0;
  logic long_hold = 1'b0;
  assign out_stall = rand_stall | long_hold;

  led_strip_spi_symbol_frame_encoder_unit #(
    .LED_COUNT  (LED_COUNT_DEF),
    .RESET_BYTES(RESET_BYTES_DEF)
  ) dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_mode       (in_mode),
    .in_red_total  (in_red_total),
    .in_green_total(in_green_total),
    .in_blue_total (in_blue_total),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_frame_byte(out_frame_byte),
    .out_frame_last(out_frame_last),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // frame model state
  int unsigned frame_pos = 0;
  logic [15:0] held_red = '0, held_green = '0, held_blue = '0;
  logic [15:0] left_red = '0, left_green = '0, left_blue = '0;
  logic [3:0]  zero_sym = ZERO_SYMBOL_RST;
  logic [3:0]  one_sym = ONE_SYMBOL_RST;

  frame_beat_t frame_bytes_due[$];

  bit tx_idle_on = 1'b1;
  bit rx_idle_on = 1'b1;
  int hold_req = 0;
  int rx_wait;

  int loads_sent = 0;
  int fetches_sent = 0;
  int frames_wrapped = 0;
  int beats_checked = 0;
  int cfg_writes = 0;
  int bad_beats = 0;

  function automatic logic [7:0] led_share(input logic [15:0] left);
    return (left < 16'd255) ? left[7:0] : 8'hFF;
  endfunction

  function automatic logic [3:0] line_symbol(input logic b);
    return b ? one_sym : zero_sym;
  endfunction

  function automatic logic [7:0] encode_led_byte(input int unsigned offset);
    int unsigned slot;
    int unsigned hi;
    logic [7:0] level;
    slot = offset % BYTES_PER_LED;
    hi = 7 - 2 * (slot % 4);
    case (slot / 4)
      0: level = led_share(left_green);
      1: level = led_share(left_red);
      default: level = led_share(left_blue);
    endcase
    return {line_symbol(level[hi - 1]), line_symbol(level[hi])};
  endfunction

  function automatic frame_beat_t next_frame_beat();
    frame_beat_t beat;
    int unsigned offset;
    beat.data = 8'h00;
    if (frame_pos >= RESET_BYTES_DEF && frame_pos < RESET_BYTES_DEF + DATA_LEN) begin
      offset = frame_pos - RESET_BYTES_DEF;
      beat.data = encode_led_byte(offset);
      if (offset % BYTES_PER_LED == BYTES_PER_LED - 1) begin
        left_red   = left_red - {8'd0, led_share(left_red)};
        left_green = left_green - {8'd0, led_share(left_green)};
        left_blue  = left_blue - {8'd0, led_share(left_blue)};
      end
    end
    beat.last = (frame_pos == FRAME_LEN - 1);
    if (beat.last) begin
      frame_pos  = 0;
      left_red   = held_red;
      left_green = held_green;
      left_blue  = held_blue;
    end else begin
      frame_pos = frame_pos + 1;
    end
    return beat;
  endfunction

  task automatic send_item(input logic mode, input logic [15:0] red, input logic [15:0] green,
                           input logic [15:0] blue);
    int gap;
    frame_beat_t beat;
    gap = tx_idle_on ? $urandom_range(0, 12) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_mode        <= mode;
    in_red_total   <= red;
    in_green_total <= green;
    in_blue_total  <= blue;
    do @(posedge clk); while (in_stall);
    if (mode == MODE_LOAD) begin
      held_red   = red;
      held_green = green;
      held_blue  = blue;
      left_red   = red;
      left_green = green;
      left_blue  = blue;
      frame_pos  = 0;
      loads_sent++;
    end else begin
      beat = next_frame_beat();
      frame_bytes_due.push_back(beat);
      fetches_sent++;
      if (beat.last) frames_wrapped++;
    end
  endtask

  task automatic load_totals(input logic [15:0] red, input logic [15:0] green,
                             input logic [15:0] blue);
    send_item(MODE_LOAD, red, green, blue);
  endtask

  task automatic fetch_bytes(input int count);
    repeat (count) send_item(MODE_FETCH, 16'($urandom), 16'($urandom), 16'($urandom));
  endtask

  // loads leave nothing in the queue, so give the pipe its latency on top
  task automatic settle();
    in_valid <= 1'b0;
    while (frame_bytes_due.size() != 0) @(posedge clk);
    repeat (LATENCY + 2) @(posedge clk);
  endtask

  task automatic write_symbol(input cfg_reg_t idx, input logic [3:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == CFG_ZERO_SYMBOL) zero_sym = value;
    else one_sym = value;
    cfg_writes++;
  endtask

  function automatic logic [15:0] pick_total();
    case ($urandom_range(0, 3))
      0: return 16'($urandom_range(0, 65535));
      1: return 16'($urandom_range(0, 1023));
      2: return 16'($urandom_range(0, 4095));
      default: begin
        case ($urandom_range(0, 3))
          0: return 16'h0000;
          1: return 16'hFFFF;
          2: return 16'd255;
          default: return 16'd256;
        endcase
      end
    endcase
  endfunction

  task automatic test_reset_state();
    fetch_bytes(RESET_BYTES_DEF + 14);
  endtask

  task automatic test_load_extremes();
    load_totals(16'hFFFF, 16'h0000, 16'hFFFF);
    fetch_bytes(RESET_BYTES_DEF + 24);
    load_totals(16'h0000, 16'hFFFF, 16'h00A5);
    fetch_bytes(RESET_BYTES_DEF + 12);
  endtask

  task automatic test_exhausted_totals();
    load_totals(16'd300, 16'd255, 16'd1);
    fetch_bytes(RESET_BYTES_DEF + 4 * BYTES_PER_LED);
  endtask

  task automatic test_restart_mid_frame();
    load_totals(pick_total(), pick_total(), pick_total());
    fetch_bytes(RESET_BYTES_DEF + 9);
    load_totals(pick_total(), pick_total(), pick_total());
    fetch_bytes(RESET_BYTES_DEF + 9);
  endtask

  task automatic test_symbol_registers();
    logic [3:0] zs [3];
    logic [3:0] os [3];
    zs = '{4'h0, 4'hF, 4'($urandom)};
    os = '{4'hF, 4'h0, 4'($urandom)};
    for (int k = 0; k < 3; k++) begin
      settle();
      write_symbol(CFG_ZERO_SYMBOL, zs[k]);
      write_symbol(CFG_ONE_SYMBOL, os[k]);
      load_totals(16'h5A5A, pick_total(), 16'h00C3);
      fetch_bytes(RESET_BYTES_DEF + BYTES_PER_LED + 2);
    end
    settle();
    write_symbol(CFG_ZERO_SYMBOL, ZERO_SYMBOL_RST);
    write_symbol(CFG_ONE_SYMBOL, ONE_SYMBOL_RST);
  endtask

  // one full frame, then into the data of the next to see the totals reloaded
  task automatic test_frame_wrap();
    load_totals(16'd1000, 16'd30000, 16'hFFFF);
    fetch_bytes(FRAME_LEN + RESET_BYTES_DEF + 2 * BYTES_PER_LED);
  endtask

  task automatic test_backpressure();
    settle();
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b0;
    load_totals(16'd777, 16'd4000, 16'd20);
    hold_req = 80;
    fetch_bytes(40);
    settle();
    rx_idle_on = 1'b1;
    fetch_bytes(40);
    settle();
    tx_idle_on = 1'b1;
  endtask

  task automatic test_random_frames(input int target);
    int sent;
    int run;
    sent = 0;
    while (sent < target) begin
      if ($urandom_range(0, 3) == 0) begin
        settle();
        if ($urandom_range(0, 1)) write_symbol(CFG_ZERO_SYMBOL, 4'($urandom));
        if ($urandom_range(0, 1)) write_symbol(CFG_ONE_SYMBOL, 4'($urandom));
      end
      tx_idle_on = ($urandom_range(0, 3) != 0);
      rx_idle_on = ($urandom_range(0, 3) != 0);
      if ($urandom_range(0, 4) != 0) begin
        load_totals(pick_total(), pick_total(), pick_total());
        run = $urandom_range(RESET_BYTES_DEF + 1, RESET_BYTES_DEF + 120);
        fetch_bytes(run);
        sent += run + 1;
      end else begin
        run = $urandom_range(1, 10);
        repeat (run) begin
          send_item(logic'($urandom_range(0, 1)), pick_total(), pick_total(), pick_total());
        end
        sent += run;
      end
    end
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
  endtask

  // result checker
  initial begin
    frame_beat_t want;
    wait (rst_n);
    forever begin
      @(posedge clk);
      if (out_valid && !out_stall) begin
        beats_checked++;
        if (frame_bytes_due.size() == 0) begin
          bad_beats++;
          if (bad_beats <= 10)
            $display("unexpected beat: byte %02h last %0b", out_frame_byte, out_frame_last);
        end else begin
          want = frame_bytes_due.pop_front();
          if (want.data !== out_frame_byte || want.last !== out_frame_last) begin
            bad_beats++;
            if (bad_beats <= 10)
              $display("mismatch: byte exp %02h got %02h, last exp %0b got %0b",
                       want.data, out_frame_byte, want.last, out_frame_last);
          end
        end
      end
    end
  end

  // receiver pacing, one draw per beat
  initial begin
    wait (rst_n);
    forever begin
      rx_wait = rx_idle_on ? $urandom_range(0, 12) : 0;
      if (rx_wait > 0) begin
        rand_stall <= 1'b1;
        repeat (rx_wait) @(posedge clk);
      end
      rand_stall <= 1'b0;
      do @(posedge clk); while (!(out_valid && !out_stall));
    end
  end

  // long receiver hold
  initial begin
    forever begin
      @(posedge clk);
      if (hold_req > 0) begin
        long_hold <= 1'b1;
        repeat (hold_req) @(posedge clk);
        long_hold <= 1'b0;
        hold_req = 0;
      end
    end
  end

  initial begin
    #5_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_state();
    test_load_extremes();
    test_exhausted_totals();
    test_restart_mid_frame();
    test_symbol_registers();
    test_frame_wrap();
    test_backpressure();
    test_random_frames(150);
    settle();
    repeat (10) @(posedge clk);
    bad_beats += frame_bytes_due.size();
    $display("Ran %0d loads and %0d fetches, %0d beats checked, %0d frame wraps.",
             loads_sent, fetches_sent, beats_checked, frames_wrapped);
    $display("Symbol registers written %0d times; %0d bad beats.", cfg_writes, bad_beats);
    if (bad_beats == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
